FILE: hw/rtl/hpbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed palette builder/encoder package
// Shared constants, operation codes and types for the palette core.
// ----------------------------------------------------------------------------
package hpbe_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_CLEAR  = 2'd0;
    localparam op_t OP_LEARN  = 2'd1;
    localparam op_t OP_ENCODE = 2'd2;
    localparam op_t OP_READ   = 2'd3;

    localparam int TABLE_SIZE_DEF  = 1024;
    localparam int MAX_COLOURS_DEF = 256;

    // Fibonacci hash: multiply modulo 2^32, keep the bits above HASH_SHIFT
    localparam logic [31:0] HASH_MULT  = 32'd2654435761;
    localparam int          HASH_SHIFT = 22;

    localparam int          COUNT_W    = 9;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

endpackage

FILE: hw/rtl/hpbe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hpbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/hashed_palette_builder_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed palette builder/encoder core
// Learns up to MAX_COLOURS distinct RGBA colours in an open-addressing hash
// table and encodes pixels as palette indexes or as direct BGRA words.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation and the pixel fields, raise start; the
//   transfer happens on a rising edge with start high and busy low.
//   Result channel: result_valid pulses for one cycle with all result fields;
//   the receiver cannot hold it off, so it must take it on that edge.
//   Clear, and learn/encode once full, give their result straight from idle.
//   Read: a colour RAM read, then the result. Learn/encode: a slot RAM read;
//   if the slot holds a colour, a colour RAM read and compare; each colliding
//   slot passed repeats both reads (slot RAM, then colour RAM and compare).
//   The probe loop through the two synchronous RAMs sets the rate: one item
//   at a time; except after a clear, busy is low while the strobe is high.
//   Reset and clear: the slot table is swept to empty, one slot per cycle,
//   busy high meanwhile. Clear gives its result at once and then sweeps.
//   The colour RAM is never cleared; entries are only used below the fill
//   count.
// ----------------------------------------------------------------------------
module hashed_palette_builder_encoder_core #(
    parameter int TABLE_SIZE  = hpbe_pkg::TABLE_SIZE_DEF,
    parameter int MAX_COLOURS = hpbe_pkg::MAX_COLOURS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  hpbe_pkg::op_t                  operation,
    input  logic [7:0]                     red,
    input  logic [7:0]                     green,
    input  logic [7:0]                     blue,
    input  logic [7:0]                     alpha_value,
    input  logic [7:0]                     entry_index,
    input  logic                           row_last,
    output logic                           result_valid,
    output logic [7:0]                     palette_index,
    output logic [31:0]                    direct_pixel,
    output logic                           is_direct,
    output logic [hpbe_pkg::COUNT_W-1:0]   colour_count,
    output logic                           palette_full,
    output logic                           has_alpha,
    output logic [31:0]                    palette_entry,
    output logic                           row_last_out
);

    import hpbe_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);        // slot address bits
    localparam int SW = $clog2(MAX_COLOURS + 1);   // slot entry / count bits
    localparam int CW = $clog2(MAX_COLOURS);       // colour address bits

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_RDW   = 3'd4;

    // Control state
    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] sweep_reg, sweep_next;
    logic [SW-1:0] count_reg, count_next;
    logic          full_reg, full_next;
    logic          alpha_reg, alpha_next;
    logic          strobe_reg, strobe_next;

    // Item payload held across the probe
    logic [IW-1:0] slot_reg, slot_next;
    logic [SW-1:0] ent_reg, ent_next;
    logic [31:0]   word_reg, word_next;
    op_t           op_reg, op_next;
    logic [7:0]    idx_reg, idx_next;
    logic          last_reg, last_next;

    // Result payload
    logic [7:0]    pal_reg, pal_next;
    logic [31:0]   direct_reg, direct_next;
    logic          is_direct_reg, is_direct_next;
    logic [31:0]   entry_reg, entry_next;
    logic          last_out_reg, last_out_next;

    // RAM ports
    logic          slot_we, slot_re;
    logic [IW-1:0] slot_waddr, slot_raddr;
    logic [SW-1:0] slot_wdata, slot_rdata;
    logic          col_we, col_re;
    logic [CW-1:0] col_waddr, col_raddr;
    logic [31:0]   col_rdata;

    logic [31:0]   word_in;
    logic [31:0]   hash_prod;
    logic [IW-1:0] hash_idx;
    logic          accept;

    assign word_in   = {red, green, blue, alpha_value};
    assign hash_prod = word_in * HASH_MULT;
    assign hash_idx  = hash_prod[HASH_SHIFT +: IW];
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;

    hpbe_ram #(
        .WIDTH (SW),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    hpbe_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLOURS)
    ) u_colour_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (word_reg),
        .re    (col_re),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    always_comb
    begin
        logic          finish;
        logic [SW-1:0] fin_ent;
        logic [8:0]    ent_wide;

        state_next     = state_reg;
        sweep_next     = sweep_reg;
        count_next     = count_reg;
        full_next      = full_reg;
        alpha_next     = alpha_reg;
        strobe_next    = 1'b0;
        slot_next      = slot_reg;
        ent_next       = ent_reg;
        word_next      = word_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        pal_next       = '0;
        direct_next    = '0;
        is_direct_next = 1'b0;
        entry_next     = '0;
        last_out_next  = last_reg;

        slot_we    = 1'b0;
        slot_waddr = slot_reg;
        slot_wdata = count_reg + 1'b1;
        slot_re    = 1'b0;
        slot_raddr = hash_idx;
        col_we     = 1'b0;
        col_waddr  = count_reg[CW-1:0];
        col_re     = 1'b0;
        col_raddr  = entry_index[CW-1:0];

        finish   = 1'b0;
        fin_ent  = '0;
        ent_wide = '0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                // empty one slot per cycle
                slot_we    = 1'b1;
                slot_waddr = sweep_reg;
                slot_wdata = '0;
                if (sweep_reg == IW'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    word_next     = word_in;
                    op_next       = operation;
                    idx_next      = entry_index;
                    last_next     = row_last;
                    last_out_next = row_last;
                    slot_next     = hash_idx;
                    unique case (operation)
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            full_next   = 1'b0;
                            alpha_next  = 1'b0;
                            sweep_next  = '0;
                            strobe_next = 1'b1;
                            state_next  = ST_SWEEP;
                        end
                        OP_LEARN:
                        begin
                            if (alpha_value != ALPHA_OPAQUE)
                            begin
                                alpha_next = 1'b1;
                            end
                            if (full_reg)
                            begin
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                slot_re    = 1'b1;
                                state_next = ST_CHK;
                            end
                        end
                        OP_ENCODE:
                        begin
                            if (full_reg)
                            begin
                                strobe_next    = 1'b1;
                                is_direct_next = 1'b1;
                                direct_next    = {alpha_value, red, green, blue};
                            end
                            else
                            begin
                                slot_re    = 1'b1;
                                state_next = ST_CHK;
                            end
                        end
                        OP_READ:
                        begin
                            col_re     = 1'b1;
                            state_next = ST_RDW;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHK:
            begin
                if (slot_rdata == '0)
                begin
                    finish  = 1'b1;
                    fin_ent = '0;
                end
                else
                begin
                    // fetch the colour this slot points to
                    col_re     = 1'b1;
                    col_raddr  = CW'(slot_rdata - 1'b1);
                    ent_next   = slot_rdata;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (col_rdata == word_reg)
                begin
                    finish  = 1'b1;
                    fin_ent = ent_reg;
                end
                else
                begin
                    // collision: advance to the next slot
                    slot_next  = slot_reg + 1'b1;
                    slot_re    = 1'b1;
                    slot_raddr = slot_reg + 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_RDW:
            begin
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
                if (9'(idx_reg) < 9'(count_reg))
                begin
                    entry_next = {col_rdata[7:0], col_rdata[31:8]};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            strobe_next = 1'b1;
            state_next  = ST_IDLE;
            if (op_reg == OP_LEARN)
            begin
                if (fin_ent == '0)
                begin
                    if (count_reg >= SW'(MAX_COLOURS))
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        col_we     = 1'b1;
                        slot_we    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            else
            begin
                // unknown colour wraps to 255
                ent_wide = 9'(fin_ent) - 9'd1;
                pal_next = ent_wide[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            sweep_reg  <= '0;
            count_reg  <= '0;
            full_reg   <= 1'b0;
            alpha_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            count_reg  <= count_next;
            full_reg   <= full_next;
            alpha_reg  <= alpha_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        ent_reg       <= ent_next;
        word_reg      <= word_next;
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        last_reg      <= last_next;
        pal_reg       <= pal_next;
        direct_reg    <= direct_next;
        is_direct_reg <= is_direct_next;
        entry_reg     <= entry_next;
        last_out_reg  <= last_out_next;
    end

    // Flags and count are updated on or before the edge that raises the strobe,
    // so the registers themselves carry the post-operation values.
    assign result_valid  = strobe_reg;
    assign palette_index = pal_reg;
    assign direct_pixel  = direct_reg;
    assign is_direct     = is_direct_reg;
    assign colour_count  = COUNT_W'(count_reg);
    assign palette_full  = full_reg;
    assign has_alpha     = alpha_reg;
    assign palette_entry = entry_reg;
    assign row_last_out  = last_out_reg;

`ifndef SYNTHESIS
    // Every result follows a transfer or work already in progress.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(busy) || $past(start)))
        else $error("result without a preceding transfer");

    // The fill count never passes the palette size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SW'(MAX_COLOURS))
        else $error("colour count past palette size");

    // Direct encoding only once the palette has overflowed.
    a_direct_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_direct) |-> palette_full)
        else $error("direct pixel while palette not full");

    // Full flag is sticky outside of a clear.
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(full_reg) && !(state_reg == ST_SWEEP && $past(state_reg) == ST_IDLE))
        |-> full_reg)
        else $error("full flag dropped without clear");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette builder/encoder core testbench
// Drives clear, learn, encode and read commands into the core and checks every
// result strobe against typed results or a cycle-free shadow of the palette.
// A short table of directed commands comes first, then random phases: small
// palettes with mixed traffic, and one phase that fills the palette past its
// capacity so that the direct-pixel encoding and the sticky flags are hit.
// ----------------------------------------------------------------------------
module tb;
    import hpbe_pkg::*;

    localparam int SLOTS   = TABLE_SIZE_DEF;
    localparam int COLOURS = MAX_COLOURS_DEF;
    localparam int RANDOM_ITEMS = 500;

    // One command as it is presented on the input ports
    typedef struct {
        op_t        op;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic [7:0] idx;
        logic       last;
    } pixel_cmd_t;

    // One result as it appears on the output ports
    typedef struct {
        logic [7:0]  pal;
        logic [31:0] direct;
        logic        is_dir;
        logic [8:0]  count;
        logic        full;
        logic        alpha;
        logic [31:0] entry;
        logic        last;
    } palette_result_t;

    // A directed row: the command, and the result where it is typed in by hand
    typedef struct {
        pixel_cmd_t      cmd;
        bit              typed;
        palette_result_t res;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    op_t         operation;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha_value;
    logic [7:0]  entry_index;
    logic        row_last;
    logic        result_valid;
    logic [7:0]  palette_index;
    logic [31:0] direct_pixel;
    logic        is_direct;
    logic [8:0]  colour_count;
    logic        palette_full;
    logic        has_alpha;
    logic [31:0] palette_entry;
    logic        row_last_out;

    // Shadow of the core's storage
    logic [8:0]  shadow_slot   [0:SLOTS-1];
    logic [31:0] shadow_colour [0:COLOURS-1];
    int          shadow_count;
    logic        shadow_full;
    logic        shadow_alpha;

    palette_result_t pending_results[$];
    directed_row_t   directed_rows[$];
    logic [31:0]     colour_pool[$];
    int              mismatches;
    int              items_sent;
    bit              quiet;

    hashed_palette_builder_encoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha_value   (alpha_value),
        .entry_index   (entry_index),
        .row_last      (row_last),
        .result_valid  (result_valid),
        .palette_index (palette_index),
        .direct_pixel  (direct_pixel),
        .is_direct     (is_direct),
        .colour_count  (colour_count),
        .palette_full  (palette_full),
        .has_alpha     (has_alpha),
        .palette_entry (palette_entry),
        .row_last_out  (row_last_out)
    );

    always #5 clk = ~clk;

    // Hard stop in case a transfer or a result never comes
    initial
    begin
        #50_000_000;
        $display("tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------

    // Empty the table and drop every palette entry and flag
    function automatic void shadow_wipe();
        for (int i = 0; i < SLOTS; i++)
            shadow_slot[i] = '0;
        for (int i = 0; i < COLOURS; i++)
            shadow_colour[i] = '0;
        shadow_count = 0;
        shadow_full  = 1'b0;
        shadow_alpha = 1'b0;
    endfunction

    // Walk the table from the hashed slot until the colour or a hole turns up
    function automatic int find_slot(input logic [31:0] word);
        logic [31:0] hashed;
        logic [8:0]  e;
        int          slot;
        bit          done;
        hashed = word * HASH_MULT;
        slot   = int'(hashed >> HASH_SHIFT) & (SLOTS - 1);
        done   = 1'b0;
        for (int n = 0; n < SLOTS && !done; n++)
        begin
            e = shadow_slot[slot];
            if (e == 0 || (e <= COLOURS && shadow_colour[e - 1] == word))
                done = 1'b1;
            else
                slot = (slot + 1) & (SLOTS - 1);
        end
        return slot;
    endfunction

    // RGBA word to the B,G,R,A byte order of the outputs
    function automatic logic [31:0] to_bgra(input logic [31:0] word);
        return {word[7:0], word[31:24], word[23:16], word[15:8]};
    endfunction

    // Apply one command to the shadow and give the result it should produce
    function automatic palette_result_t predict_palette_result(input pixel_cmd_t c);
        palette_result_t res;
        logic [31:0]     word;
        logic [8:0]      e;
        int              slot;
        word = {c.r, c.g, c.b, c.a};
        res.pal    = '0;
        res.direct = '0;
        res.is_dir = 1'b0;
        res.entry  = '0;
        case (c.op)
            OP_CLEAR:
                shadow_wipe();
            OP_LEARN:
            begin
                // Alpha is tracked even once the palette has overflowed
                if (c.a != ALPHA_OPAQUE)
                    shadow_alpha = 1'b1;
                if (!shadow_full)
                begin
                    slot = find_slot(word);
                    if (shadow_slot[slot] == 0)
                    begin
                        if (shadow_count >= COLOURS)
                            shadow_full = 1'b1;
                        else
                        begin
                            shadow_colour[shadow_count] = word;
                            shadow_count++;
                            shadow_slot[slot] = 9'(shadow_count);
                        end
                    end
                end
            end
            OP_ENCODE:
            begin
                if (shadow_full)
                begin
                    res.direct = to_bgra(word);
                    res.is_dir = 1'b1;
                end
                else
                begin
                    // An empty slot wraps to 255, same as entry 255
                    slot = find_slot(word);
                    e = shadow_slot[slot] - 9'd1;
                    res.pal = e[7:0];
                end
            end
            default:
            begin
                if (int'(c.idx) < shadow_count)
                    res.entry = to_bgra(shadow_colour[c.idx]);
            end
        endcase
        res.count = 9'(shadow_count);
        res.full  = shadow_full;
        res.alpha = shadow_alpha;
        res.last  = c.last;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Compare each strobed result with the oldest outstanding expectation
    always @(posedge clk)
    begin
        palette_result_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", {23'd0, colour_count}, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (palette_index !== want.pal)
                    report_mismatch("palette_index", 32'(palette_index), 32'(want.pal));
                if (direct_pixel !== want.direct)
                    report_mismatch("direct_pixel", direct_pixel, want.direct);
                if (is_direct !== want.is_dir)
                    report_mismatch("is_direct", 32'(is_direct), 32'(want.is_dir));
                if (colour_count !== want.count)
                    report_mismatch("colour_count", 32'(colour_count), 32'(want.count));
                if (palette_full !== want.full)
                    report_mismatch("palette_full", 32'(palette_full), 32'(want.full));
                if (has_alpha !== want.alpha)
                    report_mismatch("has_alpha", 32'(has_alpha), 32'(want.alpha));
                if (palette_entry !== want.entry)
                    report_mismatch("palette_entry", palette_entry, want.entry);
                if (row_last_out !== want.last)
                    report_mismatch("row_last_out", 32'(row_last_out), 32'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command driving
    // ------------------------------------------------------------------------

    // Present one command from a falling edge and hold it until the transfer.
    // Predict at the transfer edge, so expectations keep command order.
    task automatic transfer_item(input pixel_cmd_t c, input bit typed,
                                 input palette_result_t typed_res);
        palette_result_t res;
        bit              taken;
        while (!quiet && $urandom_range(0, 99) < 17)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        operation   <= c.op;
        red         <= c.r;
        green       <= c.g;
        blue        <= c.b;
        alpha_value <= c.a;
        entry_index <= c.idx;
        row_last    <= c.last;
        start       <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (busy === 1'b0)
                taken = 1'b1;
        end
        res = predict_palette_result(c);
        if (typed)
            res = typed_res;
        pending_results.push_back(res);
        items_sent++;
        // Quiet stretch: no sender gaps in the middle of the run
        quiet = (items_sent >= 120 && items_sent < 260);
        @(negedge clk);
    endtask

    function automatic pixel_cmd_t make_cmd(input op_t op, input logic [31:0] word,
                                            input logic [7:0] idx, input logic last);
        pixel_cmd_t c;
        c.op   = op;
        c.r    = word[31:24];
        c.g    = word[23:16];
        c.b    = word[15:8];
        c.a    = word[7:0];
        c.idx  = idx;
        c.last = last;
        return c;
    endfunction

    // Given command with a random last flag, checked by the shadow model
    task automatic send_op(input op_t op, input logic [31:0] word, input logic [7:0] idx);
        palette_result_t unused;
        unused = '{default: '0};
        transfer_item(make_cmd(op, word, idx, 1'($urandom_range(0, 1))), 1'b0, unused);
    endtask

    // Random colour, opaque in opaque_pct percent of the draws
    function automatic logic [31:0] rand_colour(input int opaque_pct);
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 99) < opaque_pct)
            w[7:0] = ALPHA_OPAQUE;
        return w;
    endfunction

    // Colour for an encode or learn: mostly one already seen in this phase
    function automatic logic [31:0] pick_colour(input int opaque_pct);
        if (colour_pool.size() != 0 && $urandom_range(0, 9) < 7)
            return colour_pool[$urandom_range(0, colour_pool.size() - 1)];
        return rand_colour(opaque_pct);
    endfunction

    // Read index: half the time inside the filled part of the palette
    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 1) == 0 && shadow_count > 0)
            return 8'($urandom_range(0, shadow_count - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // One command from the general traffic mix
    task automatic mixed_op();
        logic [31:0] w;
        int          roll;
        roll = $urandom_range(0, 99);
        w = pick_colour(75);
        if (roll < 3)
            send_op(OP_CLEAR, $urandom, 8'($urandom_range(0, 255)));
        else if (roll < 38)
        begin
            colour_pool.push_back(w);
            send_op(OP_LEARN, w, 8'($urandom_range(0, 255)));
        end
        else if (roll < 78)
            send_op(OP_ENCODE, w, 8'($urandom_range(0, 255)));
        else
            send_op(OP_READ, $urandom, pick_index());
    endtask

    // Fill the palette to capacity, probe the last entry, then overflow it
    task automatic overflow_phase();
        logic [31:0] w;
        colour_pool.delete();
        send_op(OP_CLEAR, $urandom, 8'($urandom_range(0, 255)));
        while (shadow_count < COLOURS)
        begin
            w = rand_colour(94);
            colour_pool.push_back(w);
            send_op(OP_LEARN, w, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0)
                send_op(OP_ENCODE, pick_colour(94), 8'($urandom_range(0, 255)));
        end
        // Entry 255 encodes the same as an unknown colour
        send_op(OP_ENCODE, colour_pool[colour_pool.size() - 1], 8'd0);
        send_op(OP_READ, $urandom, 8'd255);
        send_op(OP_READ, $urandom, 8'd0);
        send_op(OP_ENCODE, rand_colour(100), 8'd0);
        while (!shadow_full)
            send_op(OP_LEARN, rand_colour(94), 8'($urandom_range(0, 255)));
        // Traffic once full: direct encoding, reads, alpha still tracked
        repeat (30)
        begin
            if ($urandom_range(0, 99) < 97)
                mixed_op();
        end
    endtask

    task automatic add_row(input op_t op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a,
                           input logic [7:0] idx, input logic last, input bit typed,
                           input logic [7:0] pal, input logic [8:0] count,
                           input logic full, input logic alpha,
                           input logic [31:0] entry);
        directed_row_t row;
        row.cmd   = make_cmd(op, {r, g, b, a}, idx, last);
        row.typed = typed;
        // Typed rows never reach full mode, so no direct pixel is expected
        row.res   = '{pal: pal, direct: 32'd0, is_dir: 1'b0, count: count,
                      full: full, alpha: alpha, entry: entry, last: last};
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = OP_CLEAR;
        red         = '0;
        green       = '0;
        blue        = '0;
        alpha_value = '0;
        entry_index = '0;
        row_last    = 1'b0;
        mismatches  = 0;
        items_sent  = 0;
        quiet       = 1'b0;
        shadow_wipe();

        // Directed table: op, R, G, B, A, index, last, typed, then the result
        add_row(OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1,
                8'h00, 9'd0, 0, 0, 32'h0);
        add_row(OP_ENCODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 1,
                8'hff, 9'd0, 0, 0, 32'h0);
        add_row(OP_LEARN,  8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 1,
                8'h00, 9'd1, 0, 0, 32'h0);
        add_row(OP_LEARN,  8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1,
                8'h00, 9'd2, 0, 0, 32'h0);
        add_row(OP_ENCODE, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 1,
                8'h00, 9'd2, 0, 0, 32'h0);
        add_row(OP_ENCODE, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 1,
                8'h01, 9'd2, 0, 0, 32'h0);
        // Repeat colour: nothing new stored
        add_row(OP_LEARN,  8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 1,
                8'h00, 9'd2, 0, 0, 32'h0);
        add_row(OP_LEARN,  8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 1'b0, 1,
                8'h00, 9'd3, 0, 1, 32'h0);
        add_row(OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 1'b0, 1,
                8'h00, 9'd3, 0, 1, 32'h0012_3456);
        // Read past the fill count gives zero
        add_row(OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1,
                8'h00, 9'd3, 0, 1, 32'h0);
        add_row(OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 1'b1, 1,
                8'h00, 9'd3, 0, 1, 32'hffff_ffff);
        add_row(OP_ENCODE, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 1'b0, 0,
                8'h00, 9'd0, 0, 0, 32'h0);
        add_row(OP_ENCODE, 8'h80, 8'h01, 8'h02, 8'hfe, 8'h00, 1'b0, 1,
                8'hff, 9'd3, 0, 1, 32'h0);
        add_row(OP_LEARN,  8'h80, 8'h01, 8'h02, 8'hfe, 8'h7f, 1'b1, 0,
                8'h00, 9'd0, 0, 0, 32'h0);
        // Same RGB, other alpha: a different colour
        add_row(OP_ENCODE, 8'h80, 8'h01, 8'h02, 8'hff, 8'h80, 1'b0, 0,
                8'h00, 9'd0, 0, 0, 32'h0);
        add_row(OP_LEARN,  8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 1'b0, 0,
                8'h00, 9'd0, 0, 0, 32'h0);
        add_row(OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 1'b0, 0,
                8'h00, 9'd0, 0, 0, 32'h0);
        // Clear drops everything, flags included
        add_row(OP_CLEAR,  8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 1'b1, 1,
                8'h00, 9'd0, 0, 0, 32'h0);
        add_row(OP_READ,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1,
                8'h00, 9'd0, 0, 0, 32'h0);
        add_row(OP_ENCODE, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 1,
                8'hff, 9'd0, 0, 0, 32'h0);
        add_row(OP_LEARN,  8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 1'b1, 0,
                8'h00, 9'd0, 0, 0, 32'h0);
        add_row(OP_ENCODE, 8'h55, 8'haa, 8'h55, 8'haa, 8'h00, 1'b0, 0,
                8'h00, 9'd0, 0, 0, 32'h0);

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            transfer_item(directed_rows[i].cmd, directed_rows[i].typed,
                          directed_rows[i].res);

        // Random part: one overflow run, then small palettes with mixed traffic
        items_sent = 0;
        overflow_phase();
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                colour_pool.delete();
                send_op(OP_CLEAR, $urandom, 8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(1, 24))
            begin
                if (!shadow_full)
                begin
                    colour_pool.push_back(rand_colour(75));
                    send_op(OP_LEARN, colour_pool[colour_pool.size() - 1],
                            8'($urandom_range(0, 255)));
                end
            end
            repeat ($urandom_range(10, 30))
                mixed_op();
        end
        start <= 1'b0;

        // Drain outstanding results, then give the core time for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/hpbe_pkg.sv
hw/rtl/hpbe_ram.sv
hw/rtl/hashed_palette_builder_encoder_core.sv
tb/tb.sv
